// ===== rtl/core/sld_pkg.sv =====
// ============================================================================
// sld_pkg
// Shared widths and types for the segment to line closest point pipeline.
// ============================================================================
package sld_pkg;

  // input coordinates and first differences
  localparam int unsigned COORD_W = 16;
  localparam int unsigned DIFF_W  = COORD_W + 1;

  // split multiplier: wide signed A times narrow signed B
  localparam int unsigned MUL_AW  = 104;
  localparam int unsigned MUL_BW  = 35;
  localparam int unsigned MUL_CH  = 26;
  localparam int unsigned MUL_NCH = MUL_AW / MUL_CH;
  localparam int unsigned MUL_PPW = MUL_CH + 1 + MUL_BW;
  localparam int unsigned MUL_PW  = 122;

  // divider: divisor width and number of quotient bits
  localparam int unsigned TD_W    = 102;
  localparam int unsigned DIV_QW  = 19;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [MUL_AW-1:0]  mul_a_t;
  typedef logic signed [MUL_BW-1:0]  mul_b_t;
  typedef logic signed [MUL_PW-1:0]  mul_p_t;

endpackage

// ===== rtl/core/segment_line_distance_core.sv =====
// ============================================================================
// segment_line_distance_core
// Closest points between a 3D segment and an infinite line, with the squared
// distance between them, in a fully pipelined datapath.
// ============================================================================
// Input channel: in_valid_i / in_stall_o carry one word of twelve Q8.8
// coordinates (segment start and end, two points of the line). A word is
// taken at a rising edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i carry the closest point on the
// segment, the closest point on the line, the squared distance and status.
// A new word enters every cycle while in_stall_o is low; the pipe depth is
// set mostly by the 19 quotient-bit stages of the rounding dividers and the
// split multipliers ahead of them.
// When the receiver stalls, the output word holds and one more word lands in
// a skid register; the pipe then freezes and in_stall_o rises until the skid
// drains, so nothing is lost or repeated.
// Reset clears all valid flags and sets parallel_threshold to zero. The user
// writes it via cfg_we_i / cfg_wdata_i only while idle; no check in the block.
// ============================================================================
module segment_line_distance_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [31:0]            cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  sld_pkg::coord_t        seg_start_x_i,
  input  sld_pkg::coord_t        seg_start_y_i,
  input  sld_pkg::coord_t        seg_start_z_i,
  input  sld_pkg::coord_t        seg_end_x_i,
  input  sld_pkg::coord_t        seg_end_y_i,
  input  sld_pkg::coord_t        seg_end_z_i,
  input  sld_pkg::coord_t        line_base_x_i,
  input  sld_pkg::coord_t        line_base_y_i,
  input  sld_pkg::coord_t        line_base_z_i,
  input  sld_pkg::coord_t        line_far_x_i,
  input  sld_pkg::coord_t        line_far_y_i,
  input  sld_pkg::coord_t        line_far_z_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [23:0]     near_seg_x_o,
  output logic signed [23:0]     near_seg_y_o,
  output logic signed [23:0]     near_seg_z_o,
  output logic signed [23:0]     near_line_x_o,
  output logic signed [23:0]     near_line_y_o,
  output logic signed [23:0]     near_line_z_o,
  output logic [47:0]            dist_squared_o,
  output logic [1:0]             status_o
);

  localparam int unsigned PROD_W = 2 * sld_pkg::DIFF_W;
  localparam int unsigned DOT_W  = PROD_W + 1;
  localparam int unsigned NORM_W = PROD_W;
  localparam int unsigned SQ2_W  = 2 * DOT_W;
  localparam int unsigned DET_W  = 2 * NORM_W;
  localparam int unsigned NUM_W  = SQ2_W + 1;
  localparam int unsigned OUT_W  = 24;
  localparam int unsigned ACC_W  = OUT_W + 2;
  localparam int unsigned DF_W   = OUT_W + 1;
  localparam int unsigned DSQ_W  = 2 * DF_W;
  localparam int unsigned DIST_W = 48;
  localparam int unsigned SUM_W  = DSQ_W + 2;
  localparam int unsigned NSTG   = 34;

  localparam logic signed [ACC_W-1:0] OUT_HI = ACC_W'(2 ** (OUT_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] OUT_LO = -ACC_W'(2 ** (OUT_W - 1));
  localparam logic [DIST_W-1:0]       DIST_MAX = '1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_ZERO_DIR = 2'd2,
    ST_SAT      = 2'd3
  } status_e;

  typedef logic signed [OUT_W-1:0] out_t;

  // side data that rides along the pipe
  typedef struct {
    sld_pkg::coord_t          s  [3];
    sld_pkg::coord_t          b  [3];
    sld_pkg::diff_t           d0 [3];
    sld_pkg::diff_t           d1 [3];
    logic [NORM_W-1:0]        a11;
    logic signed [DOT_W-1:0]  d01;
    logic signed [DOT_W-1:0]  kd1;
    logic [DET_W-1:0]         ns;
    logic [DET_W-1:0]         ds;
    logic [sld_pkg::TD_W-1:0] td;
    logic                     zero;
    logic                     par;
  } carry_t;

  typedef struct {
    out_t              seg  [3];
    out_t              line [3];
    logic [DIST_W-1:0] dist_sq;
    status_e           status;
  } res_t;

  logic                     adv;
  logic [31:0]              thr_q;
  logic                     vld_q [NSTG];

  // stage 0: input capture
  sld_pkg::coord_t          ss_q [3];
  sld_pkg::coord_t          se_q [3];
  sld_pkg::coord_t          lb_q [3];
  sld_pkg::coord_t          lf_q [3];

  carry_t                   carry_d [1:31];
  carry_t                   carry_q [1:31];

  sld_pkg::diff_t           k_q [3];
  logic signed [PROD_W-1:0] p00_q [3];
  logic signed [PROD_W-1:0] p11_q [3];
  logic signed [PROD_W-1:0] p01_q [3];
  logic signed [PROD_W-1:0] pk0_q [3];
  logic signed [PROD_W-1:0] pk1_q [3];
  logic signed [DOT_W-1:0]  a00_sum;
  logic signed [DOT_W-1:0]  a11_sum;
  logic [NORM_W-1:0]        a00_q;
  logic signed [DOT_W-1:0]  kd0_q;
  logic [DET_W-1:0]         maa_q;
  logic signed [SQ2_W-1:0]  mdd_q;
  logic signed [SQ2_W-1:0]  mdk_q;
  logic signed [SQ2_W-1:0]  mak_q;
  logic [DET_W-1:0]         det_q;
  logic signed [NUM_W-1:0]  num_q;
  logic signed [sld_pkg::MUL_AW-1:0] tn_q;

  sld_pkg::mul_p_t          m_kd1ds;
  sld_pkg::mul_p_t          m_nsd01;
  sld_pkg::mul_p_t          m_a11ds;
  sld_pkg::mul_p_t          m_tnd1 [3];
  sld_pkg::mul_p_t          m_nsd0 [3];

  logic [sld_pkg::DIV_QW-1:0] qs [3];
  logic [sld_pkg::DIV_QW-1:0] ql [3];
  logic                       ngs [3];
  logic                       ngl [3];

  out_t                     ps32_d [3];
  out_t                     pl32_d [3];
  logic                     sat32_d;
  out_t                     ps32_q [3];
  out_t                     pl32_q [3];
  logic                     sat32_q;
  logic                     zero32_q;
  logic                     par32_q;

  logic signed [DSQ_W-1:0]  dsq_d [3];
  out_t                     ps33_q [3];
  out_t                     pl33_q [3];
  logic [DSQ_W-1:0]         dsq_q [3];
  logic                     sat33_q;
  logic                     zero33_q;
  logic                     par33_q;

  res_t                     res_d;
  res_t                     out_q;
  res_t                     skid_q;
  logic                     out_vld_q;
  logic                     skid_vld_q;

  // pipe advances whenever the skid register is free
  assign adv        = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  // side data: copy forward, fill in at the stage that produces each field
  always_comb begin
    for (int k = 2; k <= 31; k++) begin
      carry_d[k] = carry_q[k-1];
    end
    carry_d[1].a11  = '0;
    carry_d[1].d01  = '0;
    carry_d[1].kd1  = '0;
    carry_d[1].ns   = '0;
    carry_d[1].ds   = '0;
    carry_d[1].td   = '0;
    carry_d[1].zero = 1'b0;
    carry_d[1].par  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      carry_d[1].s[i]  = ss_q[i];
      carry_d[1].b[i]  = lb_q[i];
      carry_d[1].d0[i] = sld_pkg::DIFF_W'(se_q[i]) - sld_pkg::DIFF_W'(ss_q[i]);
      carry_d[1].d1[i] = sld_pkg::DIFF_W'(lf_q[i]) - sld_pkg::DIFF_W'(lb_q[i]);
    end

    // stage 3: dot products
    a00_sum = DOT_W'(p00_q[0]) + DOT_W'(p00_q[1]) + DOT_W'(p00_q[2]);
    a11_sum = DOT_W'(p11_q[0]) + DOT_W'(p11_q[1]) + DOT_W'(p11_q[2]);
    carry_d[3].a11 = a11_sum[NORM_W-1:0];
    carry_d[3].d01 = DOT_W'(p01_q[0]) + DOT_W'(p01_q[1]) + DOT_W'(p01_q[2]);
    carry_d[3].kd1 = DOT_W'(pk1_q[0]) + DOT_W'(pk1_q[1]) + DOT_W'(pk1_q[2]);

    // stage 6: degenerate cases and clamped segment parameter ns / ds
    carry_d[6].zero = (carry_q[5].a11 == '0);
    carry_d[6].par  = (det_q <= DET_W'(thr_q));
    carry_d[6].ns   = '0;
    carry_d[6].ds   = DET_W'(1);
    if (!carry_d[6].zero && !carry_d[6].par) begin
      if (num_q[NUM_W-1]) begin
        carry_d[6].ns = '0;
      end else if ($signed(NUM_W'(det_q)) < num_q) begin
        carry_d[6].ns = DET_W'(1);
      end else begin
        carry_d[6].ns = num_q[DET_W-1:0];
        carry_d[6].ds = det_q;
      end
    end

    // stage 9: line parameter denominator
    carry_d[9].td = carry_q[8].zero ? sld_pkg::TD_W'(1) : m_a11ds[sld_pkg::TD_W-1:0];
  end

  // registers of stages 0..5, 9, 32 and 33, and the side data
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 0
      ss_q[0] <= seg_start_x_i;  ss_q[1] <= seg_start_y_i;  ss_q[2] <= seg_start_z_i;
      se_q[0] <= seg_end_x_i;    se_q[1] <= seg_end_y_i;    se_q[2] <= seg_end_z_i;
      lb_q[0] <= line_base_x_i;  lb_q[1] <= line_base_y_i;  lb_q[2] <= line_base_z_i;
      lf_q[0] <= line_far_x_i;   lf_q[1] <= line_far_y_i;   lf_q[2] <= line_far_z_i;
      // side data
      carry_q <= carry_d;
      for (int i = 0; i < 3; i++) begin
        // stage 1
        k_q[i]   <= sld_pkg::DIFF_W'(ss_q[i]) - sld_pkg::DIFF_W'(lb_q[i]);
        // stage 2: element products
        p00_q[i] <= carry_q[1].d0[i] * carry_q[1].d0[i];
        p11_q[i] <= carry_q[1].d1[i] * carry_q[1].d1[i];
        p01_q[i] <= carry_q[1].d0[i] * carry_q[1].d1[i];
        pk0_q[i] <= k_q[i] * carry_q[1].d0[i];
        pk1_q[i] <= k_q[i] * carry_q[1].d1[i];
      end
      // stage 3
      a00_q <= a00_sum[NORM_W-1:0];
      kd0_q <= DOT_W'(pk0_q[0]) + DOT_W'(pk0_q[1]) + DOT_W'(pk0_q[2]);
      // stage 4: products of dot products
      maa_q <= a00_q * carry_q[3].a11;
      mdd_q <= carry_q[3].d01 * carry_q[3].d01;
      mdk_q <= carry_q[3].d01 * carry_q[3].kd1;
      mak_q <= $signed(DOT_W'(carry_q[3].a11)) * kd0_q;
      // stage 5: determinant and segment numerator
      det_q <= DET_W'($signed(SQ2_W'(maa_q)) - mdd_q);
      num_q <= NUM_W'(mdk_q) - NUM_W'(mak_q);
      // stage 9: line parameter numerator
      tn_q  <= carry_q[8].zero ? '0 : sld_pkg::MUL_AW'(m_kd1ds + m_nsd01);
      // stage 32
      ps32_q   <= ps32_d;
      pl32_q   <= pl32_d;
      sat32_q  <= sat32_d;
      zero32_q <= carry_q[31].zero;
      par32_q  <= carry_q[31].par;
      // stage 33
      ps33_q   <= ps32_q;
      pl33_q   <= pl32_q;
      for (int i = 0; i < 3; i++) begin
        dsq_q[i] <= dsq_d[i][DSQ_W-1:0];
      end
      sat33_q  <= sat32_q;
      zero33_q <= zero32_q;
      par33_q  <= par32_q;
    end
  end

  // stages 7-8: line parameter terms
  sld_mul_split u_mul_kd1ds (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (sld_pkg::MUL_AW'(carry_q[6].ds)),
    .b_i   (carry_q[6].kd1),
    .p_o   (m_kd1ds)
  );

  sld_mul_split u_mul_nsd01 (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (sld_pkg::MUL_AW'(carry_q[6].ns)),
    .b_i   (carry_q[6].d01),
    .p_o   (m_nsd01)
  );

  sld_mul_split u_mul_a11ds (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (sld_pkg::MUL_AW'(carry_q[6].ds)),
    .b_i   ($signed(sld_pkg::MUL_BW'(carry_q[6].a11))),
    .p_o   (m_a11ds)
  );

  // stages 10-11 products, stages 12-31 dividers, one lane per axis
  for (genvar g = 0; g < 3; g++) begin : g_axis
    sld_mul_split u_mul_tnd1 (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (tn_q),
      .b_i   (sld_pkg::MUL_BW'(carry_q[9].d1[g])),
      .p_o   (m_tnd1[g])
    );

    sld_mul_split u_mul_nsd0 (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (sld_pkg::MUL_AW'(carry_q[9].ns)),
      .b_i   (sld_pkg::MUL_BW'(carry_q[9].d0[g])),
      .p_o   (m_nsd0[g])
    );

    sld_div_pipe u_div_line (
      .clk_i (clk_i),
      .en_i  (adv),
      .n_i   (m_tnd1[g]),
      .d_i   (carry_q[11].td),
      .q_o   (ql[g]),
      .neg_o (ngl[g])
    );

    sld_div_pipe u_div_seg (
      .clk_i (clk_i),
      .en_i  (adv),
      .n_i   (m_nsd0[g]),
      .d_i   (sld_pkg::TD_W'(carry_q[11].ds)),
      .q_o   (qs[g]),
      .neg_o (ngs[g])
    );
  end

  // stage 32: apply sign, add base point, saturate
  always_comb begin
    logic signed [sld_pkg::DIV_QW:0] vs;
    logic signed [sld_pkg::DIV_QW:0] vl;
    logic signed [ACC_W-1:0]         cs;
    logic signed [ACC_W-1:0]         cl;
    sat32_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      vs = ngs[i] ? -$signed({1'b0, qs[i]}) : $signed({1'b0, qs[i]});
      vl = ngl[i] ? -$signed({1'b0, ql[i]}) : $signed({1'b0, ql[i]});
      cs = ACC_W'(carry_q[31].s[i]) + ACC_W'(vs);
      cl = ACC_W'(carry_q[31].b[i]) + ACC_W'(vl);
      if (cs > OUT_HI) begin
        ps32_d[i] = OUT_HI[OUT_W-1:0];  sat32_d = 1'b1;
      end else if (cs < OUT_LO) begin
        ps32_d[i] = OUT_LO[OUT_W-1:0];  sat32_d = 1'b1;
      end else begin
        ps32_d[i] = cs[OUT_W-1:0];
      end
      if (cl > OUT_HI) begin
        pl32_d[i] = OUT_HI[OUT_W-1:0];  sat32_d = 1'b1;
      end else if (cl < OUT_LO) begin
        pl32_d[i] = OUT_LO[OUT_W-1:0];  sat32_d = 1'b1;
      end else begin
        pl32_d[i] = cl[OUT_W-1:0];
      end
    end
  end

  // stage 33: squared per-axis differences
  always_comb begin
    logic signed [DF_W-1:0] df;
    for (int i = 0; i < 3; i++) begin
      df       = DF_W'(pl32_q[i]) - DF_W'(ps32_q[i]);
      dsq_d[i] = df * df;
    end
  end

  // stage 34: distance sum, clamp and status
  always_comb begin
    logic [SUM_W-1:0] sum;
    logic             sat;
    sum = SUM_W'(dsq_q[0]) + SUM_W'(dsq_q[1]) + SUM_W'(dsq_q[2]);
    sat = sat33_q;
    if (sum > SUM_W'(DIST_MAX)) begin
      res_d.dist_sq = DIST_MAX;
      sat           = 1'b1;
    end else begin
      res_d.dist_sq = sum[DIST_W-1:0];
    end
    for (int i = 0; i < 3; i++) begin
      res_d.seg[i]  = ps33_q[i];
      res_d.line[i] = pl33_q[i];
    end
    priority if (sat) begin
      res_d.status = ST_SAT;
    end else if (zero33_q) begin
      res_d.status = ST_ZERO_DIR;
    end else if (par33_q) begin
      res_d.status = ST_PARALLEL;
    end else begin
      res_d.status = ST_OK;
    end
  end

  // output word and skid payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (out_vld_q && out_stall_i) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end else if (!out_stall_i) begin
      out_q <= skid_q;
    end
  end

  // control: config register, valid flags, output and skid handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= '0;
      vld_q      <= '{default: 1'b0};
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (adv) begin
        vld_q[0] <= in_valid_i;
        for (int k = 1; k < NSTG; k++) begin
          vld_q[k] <= vld_q[k-1];
        end
        if (out_vld_q && out_stall_i) begin
          if (vld_q[NSTG-1]) begin
            skid_vld_q <= 1'b1;
          end
        end else begin
          out_vld_q <= vld_q[NSTG-1];
        end
      end else if (!out_stall_i) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_vld_q;
  assign near_seg_x_o   = out_q.seg[0];
  assign near_seg_y_o   = out_q.seg[1];
  assign near_seg_z_o   = out_q.seg[2];
  assign near_line_x_o  = out_q.line[0];
  assign near_line_y_o  = out_q.line[1];
  assign near_line_z_o  = out_q.line[2];
  assign dist_squared_o = out_q.dist_sq;
  assign status_o       = out_q.status;

endmodule

// ===== rtl/core/sld_mul_split.sv =====
// ============================================================================
// sld_mul_split
// Two stage signed multiplier: wide operand cut into chunks, partial products
// registered, then shifted and summed into a truncated product.
// ============================================================================
module sld_mul_split (
  input  logic                clk_i,
  input  logic                en_i,
  input  sld_pkg::mul_a_t     a_i,
  input  sld_pkg::mul_b_t     b_i,
  output sld_pkg::mul_p_t     p_o
);

  logic signed [sld_pkg::MUL_PPW-1:0] pp_d [sld_pkg::MUL_NCH];
  logic signed [sld_pkg::MUL_PPW-1:0] pp_q [sld_pkg::MUL_NCH];
  sld_pkg::mul_p_t                    sum_d;
  sld_pkg::mul_p_t                    sum_q;

  // partial products: low chunks unsigned, top chunk carries the sign
  always_comb begin
    for (int j = 0; j < sld_pkg::MUL_NCH; j++) begin
      if (j == sld_pkg::MUL_NCH - 1) begin
        pp_d[j] = $signed(a_i[j*sld_pkg::MUL_CH +: sld_pkg::MUL_CH]) * b_i;
      end else begin
        pp_d[j] = $signed({1'b0, a_i[j*sld_pkg::MUL_CH +: sld_pkg::MUL_CH]}) * b_i;
      end
    end
  end

  // weighted sum of the registered partial products
  always_comb begin
    sum_d = '0;
    for (int j = 0; j < sld_pkg::MUL_NCH; j++) begin
      sum_d = sum_d + (sld_pkg::MUL_PW'(pp_q[j]) <<< (sld_pkg::MUL_CH * j));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q  <= pp_d;
      sum_q <= sum_d;
    end
  end

  assign p_o = sum_q;

endmodule

// ===== rtl/core/sld_div_pipe.sv =====
// ============================================================================
// sld_div_pipe
// Pipelined rounding divider: one prep stage, then one quotient bit per stage.
// Returns round(|n| / d), ties away from zero, and the sign of n.
// ============================================================================
module sld_div_pipe (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  sld_pkg::mul_p_t               n_i,
  input  logic [sld_pkg::TD_W-1:0]      d_i,
  output logic [sld_pkg::DIV_QW-1:0]    q_o,
  output logic                          neg_o
);

  localparam int unsigned NW = sld_pkg::MUL_PW;
  localparam int unsigned NS = sld_pkg::DIV_QW + 1;

  logic [NW-1:0]                 rem_d [NS];
  logic [NW-1:0]                 rem_q [NS];
  logic [sld_pkg::TD_W:0]        dv_d  [NS];
  logic [sld_pkg::TD_W:0]        dv_q  [NS];
  logic [sld_pkg::DIV_QW-1:0]    qt_d  [NS];
  logic [sld_pkg::DIV_QW-1:0]    qt_q  [NS];
  logic                          ng_d  [NS];
  logic                          ng_q  [NS];
  logic [NW-1:0]                 mag;
  logic [NW-1:0]                 shf;

  always_comb begin
    // prep: dividend 2|n| + d over divisor 2d gives the rounded quotient
    mag      = n_i[NW-1] ? NW'(-n_i) : NW'(n_i);
    rem_d[0] = (mag << 1) + NW'(d_i);
    dv_d[0]  = {d_i, 1'b0};
    qt_d[0]  = '0;
    ng_d[0]  = n_i[NW-1];
    shf      = '0;
    // restoring steps, most significant quotient bit first
    for (int j = 0; j < sld_pkg::DIV_QW; j++) begin
      shf        = NW'(dv_q[j]) << (sld_pkg::DIV_QW - 1 - j);
      dv_d[j+1]  = dv_q[j];
      ng_d[j+1]  = ng_q[j];
      qt_d[j+1]  = qt_q[j];
      if (rem_q[j] >= shf) begin
        rem_d[j+1] = rem_q[j] - shf;
        qt_d[j+1][sld_pkg::DIV_QW-1-j] = 1'b1;
      end else begin
        rem_d[j+1] = rem_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      dv_q  <= dv_d;
      qt_q  <= qt_d;
      ng_q  <= ng_d;
    end
  end

  assign q_o   = qt_q[NS-1];
  assign neg_o = ng_q[NS-1];

endmodule
